// File: rtl/core/tkn_pkg.sv
// Shared types, constants and the ranking rule of the top-k neighbor list.
// Used by tkn_cell and top_k_neighbour_list_core; depends on nothing else.
package tkn_pkg;

   localparam int CLOSENESS_WIDTH = 4;
   localparam int TAG_WIDTH       = 8;
   localparam int SLOT_WIDTH      = 5;

   localparam logic [TAG_WIDTH-1:0] TAG_UNKNOWN = 8'h3F;  // '?'
   localparam logic [TAG_WIDTH-1:0] TAG_EMPTY   = 8'h00;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_DUMP  = 1'b1;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]       tag;
      logic [CLOSENESS_WIDTH-1:0] closeness;
   } info_type;

   // Command broadcast to every cell in a cycle.
   typedef struct packed {
      logic offer;   // an offer item is accepted this cycle
      logic dump;    // one slot is emitted and the list moves up one place
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   // True when the candidate outranks the entry held in a slot.
   function automatic logic outranks(info_type held, info_type cand);
      logic held_unknown;
      logic cand_unknown;
      logic result;
      held_unknown = (held.tag == TAG_UNKNOWN) || (held.tag == TAG_EMPTY);
      cand_unknown = (cand.tag == TAG_UNKNOWN);
      if (cand.closeness == '0) begin
         result = 1'b0;
      end else if (held_unknown != cand_unknown) begin
         result = held_unknown;
      end else begin
         result = cand.closeness > held.closeness;
      end
      return result;
   endfunction

endpackage

// File: rtl/core/tkn_cell.sv
// One slot of the ranked neighbor list: holds an entry, ranks the candidate
// against it and takes data from its neighbors. Depends on tkn_pkg.
module tkn_cell #(
   parameter int   INDEX_WIDTH = 20,
   parameter logic LAST_CELL   = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tkn_pkg::cell_cmd_type    cmd,
   input  logic [INDEX_WIDTH-1:0]   cand_index,
   input  tkn_pkg::info_type        cand_info,
   input  logic [INDEX_WIDTH-1:0]   above_index,
   input  tkn_pkg::info_type        above_info,
   input  logic [INDEX_WIDTH-1:0]   below_index,
   input  tkn_pkg::info_type        below_info,
   input  logic                     suffix_in,     // all cells below are outranked
   input  logic                     suffix_above,  // suffix_out of the cell above
   output logic                     suffix_out,
   output logic                     insert,
   output logic [INDEX_WIDTH-1:0]   held_index,
   output tkn_pkg::info_type        held_info
);

   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   tkn_pkg::info_type      info_ff, info_in;
   logic                   beats;

   // The last slot is never compared: the walk starts at the one above it.
   assign beats      = LAST_CELL || tkn_pkg::outranks(info_ff, cand_info);
   assign suffix_out = suffix_in && beats;
   assign insert     = !LAST_CELL && suffix_out && !suffix_above;

   always_comb begin
      index_in = index_ff;
      info_in  = info_ff;
      priority if (cmd.dump) begin
         index_in = below_index;
         info_in  = below_info;
      end else if (cmd.offer && insert) begin
         index_in = cand_index;
         info_in  = cand_info;
      end else if (cmd.offer && suffix_above) begin
         index_in = above_index;
         info_in  = above_info;
      end else begin
         // The entry stays where it is.
         index_in = index_ff;
         info_in  = info_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         info_ff  <= '0;
      end else begin
         index_ff <= index_in;
         info_ff  <= info_in;
      end
   end

   assign held_index = index_ff;
   assign held_info  = info_ff;

endmodule

// File: rtl/core/top_k_neighbour_list_core.sv
// Top level of the top-k neighbor list: a row of tkn_cell slots, the offer
// and dump control, and the result register. Depends on tkn_pkg, tkn_cell.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_tvalid/req_tready | tuser kind; tdata candidate
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser inserted; tdata entry; tlast
//
// In an offer every cell ranks the candidate against its entry at once, and a
// ripple of those results up the row picks the insertion slot. A dump moves
// the list up one cell a cycle while slot 0 is emitted, stalling while the
// result side is held; the list is empty when the last slot is out.
// Reset (synchronous) clears every slot to empty and drops any pending result.
// A result waits in the output register; a new item is taken in the same cycle
// the waiting one is taken, so a stalled result side holds the request side.
module top_k_neighbour_list_core #(
   parameter int  LIST_DEPTH  = 10,
   parameter int  INDEX_WIDTH = 20,
   localparam int REQ_WIDTH   = ((INDEX_WIDTH + 12 + 7) / 8) * 8,
   localparam int RSP_WIDTH   = ((INDEX_WIDTH + 17 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,   // kind
   input  logic [REQ_WIDTH-1:0] req_tdata,   // cand_index, cand_closeness, cand_tag
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_tuser,   // inserted
   output logic [RSP_WIDTH-1:0] rsp_tdata,   // slot, entry_index, entry_closeness,
                                             // entry_tag
   output logic                 rsp_tlast
);

   localparam int CNT_WIDTH = $clog2(LIST_DEPTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(LIST_DEPTH - 1);

   // Unpack the request item.
   logic [INDEX_WIDTH-1:0] cand_index;
   tkn_pkg::info_type      cand_info;

   assign cand_index          = req_tdata[INDEX_WIDTH-1:0];
   assign cand_info.closeness = req_tdata[INDEX_WIDTH+3:INDEX_WIDTH];
   assign cand_info.tag       = req_tdata[INDEX_WIDTH+11:INDEX_WIDTH+4];

   // Control state.
   tkn_pkg::state_type     state_ff, state_in;
   logic [CNT_WIDTH-1:0]   dump_cnt_ff, dump_cnt_in;
   logic                   out_free;
   logic                   offer_acc;
   logic                   dump_acc;
   logic                   dump_step;
   tkn_pkg::cell_cmd_type  cmd;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tkn_pkg::SLOT_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic                        rsp_ins_ff, rsp_ins_in;
   logic [INDEX_WIDTH-1:0]      rsp_index_ff, rsp_index_in;
   tkn_pkg::info_type           rsp_info_ff, rsp_info_in;
   logic                        rsp_last_ff, rsp_last_in;

   // Cell row wiring.
   logic [INDEX_WIDTH-1:0] held_index [LIST_DEPTH];
   tkn_pkg::info_type      held_info  [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  suffix;
   logic [LIST_DEPTH-1:0]  insert_vec;
   logic [tkn_pkg::SLOT_WIDTH-1:0] ins_slot;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign offer_acc = req_tvalid && req_tready && (req_tuser == tkn_pkg::KIND_OFFER);
   assign dump_acc  = req_tvalid && req_tready && (req_tuser == tkn_pkg::KIND_DUMP);
   assign cmd.offer = offer_acc;
   assign cmd.dump  = dump_step;

   genvar g;
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
         logic [INDEX_WIDTH-1:0] above_index, below_index;
         tkn_pkg::info_type      above_info, below_info;
         logic                   suffix_in, suffix_above;

         if (g == 0) begin : g_top
            assign above_index  = '0;
            assign above_info   = '0;
            assign suffix_above = 1'b0;
         end else begin : g_mid
            assign above_index  = held_index[g-1];
            assign above_info   = held_info[g-1];
            assign suffix_above = suffix[g-1];
         end

         if (g == LIST_DEPTH - 1) begin : g_end
            // The last cell refills with an empty entry while dumping.
            assign below_index = '0;
            assign below_info  = '0;
            assign suffix_in   = 1'b1;
         end else begin : g_inner
            assign below_index = held_index[g+1];
            assign below_info  = held_info[g+1];
            assign suffix_in   = suffix[g+1];
         end

         tkn_cell #(
            .INDEX_WIDTH (INDEX_WIDTH),
            .LAST_CELL   ((g == LIST_DEPTH - 1) ? 1'b1 : 1'b0)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd),
            .cand_index   (cand_index),
            .cand_info    (cand_info),
            .above_index  (above_index),
            .above_info   (above_info),
            .below_index  (below_index),
            .below_info   (below_info),
            .suffix_in    (suffix_in),
            .suffix_above (suffix_above),
            .suffix_out   (suffix[g]),
            .insert       (insert_vec[g]),
            .held_index   (held_index[g]),
            .held_info    (held_info[g])
         );
      end
   endgenerate

   // At most one cell claims the candidate, so OR-ing the positions encodes it.
   always_comb begin
      ins_slot = '0;
      for (int j = 0; j < LIST_DEPTH; j++) begin
         if (insert_vec[j]) begin
            ins_slot = ins_slot | tkn_pkg::SLOT_WIDTH'(j);
         end
      end
   end

   // Next state and outputs of the controller.
   always_comb begin
      state_in     = state_ff;
      dump_cnt_in  = dump_cnt_ff;
      req_tready   = 1'b0;
      dump_step    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_ins_in   = rsp_ins_ff;
      rsp_index_in = rsp_index_ff;
      rsp_info_in  = rsp_info_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         tkn_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (dump_acc) begin
               state_in    = tkn_pkg::ST_DUMP;
               dump_cnt_in = '0;
            end
            if (offer_acc) begin
               // A rejected offer reports slot 0 with inserted clear.
               rsp_valid_in = 1'b1;
               rsp_slot_in  = ins_slot;
               rsp_ins_in   = |insert_vec;
               rsp_index_in = cand_index;
               rsp_info_in  = cand_info;
               rsp_last_in  = 1'b1;
            end
         end
         tkn_pkg::ST_DUMP: begin
            dump_step = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = tkn_pkg::SLOT_WIDTH'(dump_cnt_ff);
               rsp_ins_in   = 1'b0;
               rsp_index_in = held_index[0];
               rsp_info_in  = held_info[0];
               rsp_last_in  = (dump_cnt_ff == CNT_LAST);
               if (dump_cnt_ff == CNT_LAST) begin
                  state_in    = tkn_pkg::ST_IDLE;
                  dump_cnt_in = '0;
               end else begin
                  dump_cnt_in = dump_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = tkn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkn_pkg::ST_IDLE;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ins_ff   <= rsp_ins_in;
      rsp_index_ff <= rsp_index_in;
      rsp_info_ff  <= rsp_info_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ins_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_WIDTH'({rsp_info_ff.tag, rsp_info_ff.closeness,
                                   rsp_index_ff, rsp_slot_ff});

   // The candidate lands in at most one slot.
   a_insert_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(insert_vec))
      else $error("candidate claimed by more than one slot");

   // An inserted candidate never lands in the last slot.
   a_not_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ins_ff) |->
         (rsp_slot_ff != tkn_pkg::SLOT_WIDTH'(LIST_DEPTH - 1)))
      else $error("insertion reported at the last slot");

   // A dump starts emitting from slot 0.
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      dump_acc |=> (state_ff == tkn_pkg::ST_DUMP) && (dump_cnt_ff == '0))
      else $error("dump did not start at slot 0");

   // After the final slot of a dump the controller is idle again.
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (dump_step && (dump_cnt_ff == CNT_LAST)) |=>
         (state_ff == tkn_pkg::ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("dump did not finish after the final slot");

   // Only the final item of a dump carries last.
   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      (dump_step && (dump_cnt_ff != CNT_LAST)) |=> !rsp_last_ff)
      else $error("last raised before the final dumped slot");

endmodule
